// ===== sv/tgce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgce_pkg
// Shared types, constants and tables of the truncated Gaussian column block.
// ----------------------------------------------------------------------------
package tgce_pkg;

  localparam int ROWS        = 64;
  localparam int ROW_W       = 6;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 40;
  localparam int EPS_W       = 24;
  localparam int DENS_W      = 18;

  localparam logic [7:0]  ROWS_LIM   = 8'(ROWS);
  localparam logic [6:0]  ROWS_FINAL = 7'(ROWS);
  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
  localparam logic [DENS_W-1:0] DENS_MAX = {DENS_W{1'b1}};
  localparam logic [EPS_W-1:0]  EPS_RESET = 24'd17;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // ceil(2^34 / k): exact floor division by k for numerators below 2^30
  function automatic logic [34:0] recip(input logic [3:0] k);
    logic [34:0] r;
    case (k)
      4'd1:    r = 35'd17179869184;
      4'd2:    r = 35'd8589934592;
      4'd3:    r = 35'd5726623062;
      4'd4:    r = 35'd4294967296;
      4'd5:    r = 35'd3435973837;
      4'd6:    r = 35'd2863311531;
      4'd7:    r = 35'd2454267027;
      4'd8:    r = 35'd2147483648;
      4'd9:    r = 35'd1908874354;
      4'd10:   r = 35'd1717986919;
      4'd11:   r = 35'd1561806290;
      4'd12:   r = 35'd1431655766;
      default: r = 35'd0;
    endcase
    return r;
  endfunction

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_BLEND, OP_DMUL, OP_DSUM, OP_SQRT, OP_DIV_INIT, OP_DIV,
    OP_THR, OP_GAUSS_N, OP_N_INC, OP_WIN, OP_GAUSS_ROW, OP_DENS, OP_EMIT,
    OP_EMIT_EMPTY
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic v_zero;
    logic n_at_lim;
    logic e_le_thr;
    logic win_empty;
    logic row_final;
    logic out_free;
    logic g_done;
  } dp_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_BLEND, ST_CHKV, ST_DSUM, ST_SQRT, ST_DIVI, ST_DIV, ST_THR,
    ST_SCHK, ST_SWAIT, ST_WIN, ST_WCHK, ST_RGO, ST_RWAIT, ST_DENS, ST_EMIT,
    ST_EMPTY
  } ctrl_state_t;

  typedef enum logic [3:0] {
    G_IDLE, G_CMP, G_DIV, G_HA, G_HB, G_HC, G_SA, G_SB
  } gauss_state_t;

endpackage

// ===== sv/tgce_gauss.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgce_gauss
// Multi-cycle exp(-d^2/(2*var)) unit, Q.28 result; Horner and squaring steps share one multiplier path.
// ----------------------------------------------------------------------------
module tgce_gauss (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] dist_mag, // distance magnitude, Q.9
  input  logic [32:0] var_q,    // blended variance V
  output logic        done,
  output logic [28:0] e_out
);
  import tgce_pkg::*;

  gauss_state_t state, state_next;
  logic [33:0] d2;
  logic [32:0] rem;
  logic        lb;
  logic [20:0] q;
  logic [4:0]  cnt;
  logic [3:0]  k;
  logic [30:0] e;
  logic [60:0] prod;
  logic [64:0] prod2;
  logic [33:0] rem2;
  logic        ge;
  logic [29:0] u;
  logic [29:0] p;
  logic [30:0] e_sq;

  always_comb begin
    rem2 = {rem, (cnt == 5'd20) ? lb : 1'b0};
    ge   = rem2 >= {1'b0, var_q};
    u    = {q, 9'd0};
    p    = prod[59:30];
    e_sq = prod[60:30];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == G_CMP && d2 >= {var_q, 1'b0}) ||
               (state == G_SB && cnt == 5'd0);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      G_IDLE: if (start) state_next = G_CMP;
      G_CMP:  state_next = (d2 >= {var_q, 1'b0}) ? G_IDLE : G_DIV;
      G_DIV:  if (cnt == 5'd0) state_next = G_HA;
      G_HA:   state_next = G_HB;
      G_HB:   state_next = G_HC;
      G_HC:   state_next = (k == 4'd1) ? G_SA : G_HA;
      G_SA:   state_next = G_SB;
      G_SB:   state_next = (cnt == 5'd0) ? G_IDLE : G_SA;
      default: state_next = G_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      G_IDLE: if (start) d2 <= 34'(dist_mag) * 34'(dist_mag);
      G_CMP: begin
        // beyond t = 32 the density is taken as zero
        if (d2 >= {var_q, 1'b0}) begin
          e_out <= 29'd0;
        end else begin
          rem <= d2[33:1];
          lb  <= d2[0];
          q   <= 21'd0;
          cnt <= 5'd20;
        end
      end
      G_DIV: begin
        rem <= ge ? 33'(rem2 - {1'b0, var_q}) : rem2[32:0];
        q   <= {q[19:0], ge};
        if (cnt == 5'd0) begin
          e <= ONE_Q30;
          k <= 4'd12;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
      G_HA: prod  <= 61'(u) * 61'(e);
      G_HB: prod2 <= 65'(p) * 65'(recip(k));
      G_HC: begin
        e <= ONE_Q30 - {1'b0, prod2[63:34]};
        if (k == 4'd1) cnt <= 5'd4;
        else k <= k - 4'd1;
      end
      G_SA: prod <= 61'(e) * 61'(e);
      G_SB: begin
        e <= e_sq;
        if (cnt == 5'd0) e_out <= e_sq[30:2];
        else cnt <= cnt - 5'd1;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/tgce_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgce_dp
// Datapath: blend, square root, reciprocal, half-width search, row densities.
// ----------------------------------------------------------------------------
module tgce_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  tgce_pkg::dp_cmd_t                   cmd,
  output tgce_pkg::dp_stat_t                  stat,
  input  logic [tgce_pkg::IN_TDATA_W-1:0]     in_data,
  input  logic                                cfg_valid,
  input  logic [tgce_pkg::EPS_W-1:0]          cfg_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [tgce_pkg::ROW_W-1:0]          row_index,
  output logic [tgce_pkg::DENS_W-1:0]         density,
  output logic [tgce_pkg::ROW_W-1:0]          window_first,
  output logic [tgce_pkg::ROW_W-1:0]          window_final,
  output logic                                window_empty,
  output logic                                run_last
);
  import tgce_pkg::*;

  logic [EPS_W-1:0] eps;
  logic [31:0] pa, pb;
  logic [30:0] qa, qb;
  logic [32:0] vsum;
  logic [31:0] msum;
  logic [47:0] pd_lo;
  logic [46:0] pd_hi;
  logic [63:0] sx, sres, sbit, st, dfull;
  logic [32:0] drem;
  logic [33:0] r2;
  logic        dge;
  logic [48:0] dq;
  logic [58:0] thr;
  logic [7:0]  n, mf, lim;
  logic [16:0] m9;
  logic [7:0]  first_r;
  logic [6:0]  final_r, irow;
  logic        empty_r;
  logic [63:0] dens_p;
  logic [9:0]  lo;
  logic [8:0]  hi;
  logic [7:0]  first_next;
  logic [6:0]  final_next;
  logic [17:0] diff, mag;
  logic [16:0] g_dist;
  logic        g_start, g_done;
  logic [28:0] g_e;
  logic [34:0] f;
  logic [27:0] dens_hi;

  assign mf  = msum[31:24];
  assign m9  = msum[31:15];
  assign lim = (mf > ROWS_LIM) ? mf : ROWS_LIM;
  assign f   = dq[34:0];
  assign st  = sres + sbit;
  assign dfull = {pd_hi, 17'd0} + {16'd0, pd_lo};
  assign r2  = {drem, 1'b0};
  assign dge = r2 >= {2'd0, sres[31:0]};
  assign dens_hi = dens_p[63:36];

  always_comb begin
    lo = {2'd0, mf} - {2'd0, n};
    hi = {1'b0, mf} + {1'b0, n};
    first_next = (lo[9] || lo == 10'd0) ? 8'd1 : lo[7:0];
    final_next = (hi > 9'(ROWS)) ? ROWS_FINAL : hi[6:0];
    diff = {2'd0, irow, 9'd0} - {1'b0, m9};
    mag  = diff[17] ? 18'(-diff) : diff;
    g_start = (cmd.op == OP_GAUSS_N) || (cmd.op == OP_GAUSS_ROW);
    g_dist  = (cmd.op == OP_GAUSS_ROW) ? mag[16:0] : {n, 9'd0};
  end

  tgce_gauss u_gauss (
    .clk      (clk),
    .rst      (rst),
    .start    (g_start),
    .dist_mag (g_dist),
    .var_q    (vsum),
    .done     (g_done),
    .e_out    (g_e)
  );

  always_comb begin
    stat.v_zero    = (vsum == 33'd0);
    stat.n_at_lim  = (n >= lim);
    stat.e_le_thr  = 59'({g_e, 20'd0}) <= thr;
    stat.win_empty = empty_r;
    stat.row_final = (irow == final_r);
    stat.out_free  = !out_valid || out_ready;
    stat.g_done    = g_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eps       <= EPS_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) eps <= cfg_data;
      if (cmd.op == OP_EMIT || cmd.op == OP_EMIT_EMPTY) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        pa <= 32'(in_data[77:62]) * 32'(in_data[30:15]);
        pb <= 32'(in_data[93:78]) * 32'(in_data[61:46]);
        qa <= 31'(in_data[77:62]) * 31'(in_data[14:0]);
        qb <= 31'(in_data[93:78]) * 31'(in_data[45:31]);
      end
      OP_BLEND: begin
        vsum <= {1'b0, pa} + {1'b0, pb};
        msum <= {1'b0, qa} + {1'b0, qb};
      end
      OP_DMUL: begin
        pd_lo <= 48'(vsum[16:0]) * 48'(TWO_PI_Q28);
        pd_hi <= 47'(vsum[32:17]) * 47'(TWO_PI_Q28);
      end
      OP_DSUM: begin
        sx   <= {1'b0, dfull[63:1]};
        sres <= 64'd0;
        sbit <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT: begin
        if (sx >= st) begin
          sx   <= sx - st;
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
      end
      OP_DIV_INIT: begin
        drem <= 33'd1;
        dq   <= 49'd0;
      end
      OP_DIV: begin
        drem <= dge ? 33'(r2 - {2'd0, sres[31:0]}) : r2[32:0];
        dq   <= {dq[47:0], dge};
      end
      OP_THR: begin
        thr <= 59'(eps) * 59'(f);
        n   <= 8'd0;
      end
      OP_N_INC: n <= n + 8'd1;
      OP_WIN: begin
        first_r <= first_next;
        final_r <= final_next;
        empty_r <= first_next > {1'b0, final_next};
        irow    <= first_next[6:0];
      end
      OP_DENS: dens_p <= 64'(f) * 64'(g_e);
      OP_EMIT: begin
        row_index    <= ROW_W'(irow - 7'd1);
        density      <= (dens_hi > 28'(DENS_MAX)) ? DENS_MAX : dens_hi[DENS_W-1:0];
        window_first <= ROW_W'(first_r - 8'd1);
        window_final <= ROW_W'(final_r - 7'd1);
        window_empty <= 1'b0;
        run_last     <= (irow == final_r);
        irow         <= irow + 7'd1;
      end
      OP_EMIT_EMPTY: begin
        row_index    <= '0;
        density      <= '0;
        window_first <= '0;
        window_final <= '0;
        window_empty <= 1'b1;
        run_last     <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/tgce_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgce_ctrl
// Sequencer: steps the datapath through setup, search and row emission.
// ----------------------------------------------------------------------------
module tgce_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output tgce_pkg::dp_cmd_t  cmd,
  input  tgce_pkg::dp_stat_t stat
);
  import tgce_pkg::*;

  ctrl_state_t state, state_next;
  logic [5:0]  cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= 6'd0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.op     = OP_NONE;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_BLEND;
        end
      end
      ST_BLEND: begin
        cmd.op     = OP_BLEND;
        state_next = ST_CHKV;
      end
      ST_CHKV: begin
        if (stat.v_zero) begin
          state_next = ST_EMPTY;
        end else begin
          cmd.op     = OP_DMUL;
          state_next = ST_DSUM;
        end
      end
      ST_DSUM: begin
        cmd.op     = OP_DSUM;
        cnt_next   = 6'd31;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op = OP_SQRT;
        if (cnt == 6'd0) state_next = ST_DIVI;
        else cnt_next = cnt - 6'd1;
      end
      ST_DIVI: begin
        cmd.op     = OP_DIV_INIT;
        cnt_next   = 6'd48;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (cnt == 6'd0) state_next = ST_THR;
        else cnt_next = cnt - 6'd1;
      end
      ST_THR: begin
        cmd.op     = OP_THR;
        state_next = ST_SCHK;
      end
      ST_SCHK: begin
        if (stat.n_at_lim) begin
          state_next = ST_WIN;
        end else begin
          cmd.op     = OP_GAUSS_N;
          state_next = ST_SWAIT;
        end
      end
      ST_SWAIT: begin
        if (stat.g_done) begin
          if (stat.e_le_thr) begin
            state_next = ST_WIN;
          end else begin
            cmd.op     = OP_N_INC;
            state_next = ST_SCHK;
          end
        end
      end
      ST_WIN: begin
        cmd.op     = OP_WIN;
        state_next = ST_WCHK;
      end
      ST_WCHK: state_next = stat.win_empty ? ST_EMPTY : ST_RGO;
      ST_RGO: begin
        cmd.op     = OP_GAUSS_ROW;
        state_next = ST_RWAIT;
      end
      ST_RWAIT: if (stat.g_done) state_next = ST_DENS;
      ST_DENS: begin
        cmd.op     = OP_DENS;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = stat.row_final ? ST_IDLE : ST_RGO;
        end
      end
      ST_EMPTY: begin
        if (stat.out_free) begin
          cmd.op     = OP_EMIT_EMPTY;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/truncated_gaussian_column_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// truncated_gaussian_column_eval
// Blend two shape columns into one Gaussian, find its clipped row window and
// stream the density of every row in that window.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+----------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | one column pair per item
//  m_axis   | out | m_axis_tvalid/tready   | one row density per item, tlast
//  cfg      | in  | cfg_valid/cfg_ready    | eps_threshold, Q0.24
//
//  Setup, with the window step, runs 32 square-root steps and 49 reciprocal
//  steps. Each half-width test and each row then runs the full exp path
//  (21 division steps, 12 Horner steps, 5 squarings); a distance beyond
//  t = 32 skips that work.
//  Reset clears the sequencer and sets eps_threshold to 17.
//  A stalled result holds in the output register; the next item is taken as
//  soon as the final result of the current one sits there.
//
module truncated_gaussian_column_eval (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // mean_a[14:0] variance_a[30:15] mean_b[45:31] variance_b[61:46]
  // weight_a[77:62] weight_b[93:78], zero pad above
  input  logic [tgce_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // row_index[5:0] density[23:6] window_first[29:24] window_final[35:30],
  // zero pad above
  output logic [tgce_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast,
  output logic                                m_axis_tuser,  // window_empty
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tgce_pkg::EPS_W-1:0]          cfg_data
);
  import tgce_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [ROW_W-1:0]  row_index, window_first, window_final;
  logic [DENS_W-1:0] density;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  tgce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  tgce_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_data      (s_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .row_index    (row_index),
    .density      (density),
    .window_first (window_first),
    .window_final (window_final),
    .window_empty (m_axis_tuser),
    .run_last     (m_axis_tlast)
  );

  // pack result fields, lowest field first
  assign m_axis_tdata = {4'd0, window_final, window_first, density, row_index};

endmodule
